// ===== design/phtre_pkg.sv =====
// ----------------------------------------------------------------------------
// phtre_pkg
// Shared types and constants of the probed hash table: operation codes,
// the input and result item layouts and the layout of one stored slot.
// ----------------------------------------------------------------------------
package phtre_pkg;

  localparam int unsigned TableDepthDef = 64;
  localparam logic [31:0] EmptyKeyDef = 32'h0000_0000;
  localparam logic signed [7:0] DefaultLevelRst = -8'sd120;

  // Operation carried by an input item.
  typedef enum logic [1:0] {
    FUNC_UPDATE  = 2'd0,
    FUNC_LOOKUP  = 2'd1,
    FUNC_CLEAR   = 2'd2,
    FUNC_RST_OVF = 2'd3
  } func_e;

  typedef struct packed {
    func_e              func;
    logic [31:0]        key;
    logic [15:0]        hit_count;
    logic signed [7:0]  level_dbm;
    logic [31:0]        now_time;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic               evicted;
    logic signed [7:0]  out_level;
    logic [15:0]        out_count;
    logic [31:0]        out_time;
    logic [31:0]        version_now;
    logic [6:0]         used_entries;
    logic [31:0]        overflows;
  } out_item_t;

  // One table entry as held in the slot memory.
  typedef struct packed {
    logic               valid;
    logic [31:0]        key;
    logic [15:0]        count;
    logic signed [7:0]  level;
    logic [31:0]        stamp;
  } slot_t;

endpackage

// ===== design/phtre_mod.sv =====
// ----------------------------------------------------------------------------
// phtre_mod
// Home slot unit: reduces a 32-bit key modulo the table depth. A power-of-two
// depth is a mask of the low key bits. Any other depth registers the key, then
// a reciprocal multiplication gives the quotient, then a multiply and subtract
// gives the remainder.
// ----------------------------------------------------------------------------
module phtre_mod
  import phtre_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [31:0]                    key_i,
  output logic                           done_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] rem_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam bit IsPow2 = (TABLE_DEPTH == (1 << IdxW));

  logic [IdxW-1:0] rem_q, rem_d;
  logic            done_q, done_d;

  generate
    if (IsPow2) begin : g_mask
      always_comb begin
        rem_d  = rem_q;
        done_d = start_i;
        if (start_i) begin
          rem_d = key_i[IdxW-1:0];
        end
      end
    end else begin : g_recip
      // With L = IdxW and M = floor(2^(32+L) / depth) + 1, the quotient of any
      // 32-bit key is (key * M) >> (32+L). M lies between 2^32 and 2^33, so
      // only its low word needs the multiplier; its top bit is an added
      // shifted copy of the key.
      localparam logic [63:0] RecipFull =
        ((64'd1 << (32 + IdxW)) / 64'(TABLE_DEPTH)) + 64'd1;
      localparam logic [31:0] RecipLo = RecipFull[31:0];
      localparam logic [31:0] DepthW  = 32'(TABLE_DEPTH);

      logic [31:0] key_q, key_d;
      logic [31:0] quo_q, quo_d;
      logic        mul_q, mul_d;
      logic        sub_q, sub_d;
      logic [64:0] prod;
      logic [31:0] back;

      always_comb begin
        prod   = ({33'd0, key_q} * {33'd0, RecipLo}) + {1'b0, key_q, 32'd0};
        back   = quo_q * DepthW;
        key_d  = start_i ? key_i : key_q;
        quo_d  = mul_q ? 32'(prod >> (32 + IdxW)) : quo_q;
        rem_d  = sub_q ? IdxW'(key_q - back) : rem_q;
        mul_d  = start_i;
        sub_d  = mul_q;
        done_d = sub_q;
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          mul_q <= 1'b0;
          sub_q <= 1'b0;
        end else begin
          mul_q <= mul_d;
          sub_q <= sub_d;
        end
      end

      always_ff @(posedge clk_i) begin
        key_q <= key_d;
        quo_q <= quo_d;
      end
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== design/phtre_store.sv =====
// ----------------------------------------------------------------------------
// phtre_store
// Slot memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module phtre_store
  import phtre_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  logic                           clk_i,
  input  logic                           wr_en_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr_i,
  input  slot_t                          wr_data_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr_i,
  output slot_t                          rd_data_o
);

  slot_t mem [TABLE_DEPTH];
  slot_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/probed_hash_table_with_ring_eviction.sv =====
// ----------------------------------------------------------------------------
// probed_hash_table_with_ring_eviction
// Update and lookup pass through home slot reduction (S_HASH), a read issue
// (S_ISSUE) and a probe of 1 to TABLE_DEPTH slots (S_PROBE, one slot per cycle
// through the slot memory read port) before the result waits in S_DONE. Clear
// sweeps every slot; overflow reset goes straight to S_DONE. One item at a
// time. After reset a sweep empties the slot memory.
// ----------------------------------------------------------------------------
module probed_hash_table_with_ring_eviction
  import phtre_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef,
  parameter logic [31:0] EMPTY_KEY   = EmptyKeyDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic signed [7:0] cfg_data_i
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned OccW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);
  localparam logic [OccW-1:0] FullOcc = OccW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_HASH,
    S_ISSUE,
    S_PROBE,
    S_CLEAR,
    S_DONE
  } state_e;

  // Per-item result fields gathered before the counters are appended.
  typedef struct packed {
    logic              found;
    logic              evicted;
    logic signed [7:0] level;
    logic [15:0]       count;
    logic [31:0]       stamp;
  } res_t;

  state_e            state_q, state_d;
  in_item_t          item_q, item_d;
  res_t              res_q, res_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   probes_q, probes_d;
  logic [IdxW-1:0]   sweep_q, sweep_d;
  logic [IdxW-1:0]   head_q, head_d;
  logic [OccW-1:0]   occ_q, occ_d;
  logic [31:0]       ver_q, ver_d;
  logic [31:0]       ovf_q, ovf_d;
  logic signed [7:0] dflt_q, dflt_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              mod_start;
  logic              mod_done;
  logic [IdxW-1:0]   mod_rem;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  slot_t             wr_data;
  logic [IdxW-1:0]   rd_addr;
  slot_t             rd_slot;
  logic [IdxW-1:0]   idx_next;
  logic              key_hit;
  logic              probe_end;
  logic              probe_full;
  slot_t             empty_slot;

  // The home slot is found by the reduction unit.
  phtre_mod #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mod_start),
    .key_i  (in_data_i.key),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  phtre_store #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_slot)
  );

  // While probing, the memory is read one slot ahead, so that each cycle
  // checks one slot: the data present belongs to idx_q.
  assign idx_next   = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
  assign rd_addr    = (state_q == S_PROBE) ? idx_next : idx_q;
  assign key_hit    = rd_slot.valid && (rd_slot.key == item_q.key);
  assign probe_full = rd_slot.valid && !key_hit && (probes_q == LastIdx);
  assign probe_end  = !rd_slot.valid || key_hit || probe_full;

  always_comb begin
    empty_slot       = '0;
    empty_slot.key   = EMPTY_KEY;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    res_d       = res_q;
    idx_d       = idx_q;
    probes_d    = probes_q;
    sweep_d     = sweep_q;
    head_d      = head_q;
    occ_d       = occ_q;
    ver_d       = ver_q;
    ovf_d       = ovf_q;
    dflt_d      = dflt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mod_start   = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_data     = empty_slot;

    if (cfg_valid_i) begin
      dflt_d = cfg_data_i;
    end

    // The result register is freed when its transfer completes.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q) inside
      S_INIT, S_CLEAR: begin
        // Sweep every slot back to empty, one slot per cycle.
        wr_en   = 1'b1;
        wr_addr = sweep_q;
        if (sweep_q == LastIdx) begin
          head_d  = '0;
          occ_d   = '0;
          state_d = (state_q == S_INIT) ? S_IDLE : S_DONE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          res_d  = '0;
          unique case (in_data_i.func) inside
            FUNC_UPDATE, FUNC_LOOKUP: begin
              mod_start = 1'b1;
              state_d   = S_HASH;
            end
            FUNC_CLEAR: begin
              ver_d   = ver_q + 32'd1;
              sweep_d = '0;
              state_d = S_CLEAR;
            end
            FUNC_RST_OVF: begin
              ovf_d   = '0;
              state_d = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_HASH: begin
        if (mod_done) begin
          idx_d    = mod_rem;
          probes_d = '0;
          state_d  = S_ISSUE;
        end
      end

      S_ISSUE: begin
        state_d = S_PROBE;
      end

      S_PROBE: begin
        if (!probe_end) begin
          idx_d    = idx_next;
          probes_d = probes_q + 1'b1;
        end else begin
          state_d = S_DONE;
          if (item_q.func == FUNC_UPDATE) begin
            ver_d             = ver_q + 32'd1;
            wr_en             = 1'b1;
            wr_data.valid     = 1'b1;
            wr_data.key       = item_q.key;
            wr_data.count     = item_q.hit_count;
            wr_data.level     = item_q.level_dbm;
            wr_data.stamp     = item_q.now_time;
            if (probe_full) begin
              // Every slot is taken by another key: replace the ring head.
              wr_addr       = head_q;
              head_d        = (head_q == LastIdx) ? '0 : head_q + 1'b1;
              ovf_d         = ovf_q + 32'd1;
              res_d.evicted = 1'b1;
            end else begin
              wr_addr = idx_q;
              if (!rd_slot.valid) begin
                occ_d = occ_q + 1'b1;
              end
            end
          end else if (key_hit) begin
            res_d.found = 1'b1;
            res_d.level = rd_slot.level;
            res_d.count = rd_slot.count;
            res_d.stamp = rd_slot.stamp;
          end else begin
            res_d.level = dflt_q;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d        = 1'b1;
          out_d.found        = res_q.found;
          out_d.evicted      = res_q.evicted;
          out_d.out_level    = res_q.level;
          out_d.out_count    = res_q.count;
          out_d.out_time     = res_q.stamp;
          out_d.version_now  = ver_q;
          out_d.used_entries = 7'(occ_q);
          out_d.overflows    = ovf_q;
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      sweep_q     <= '0;
      head_q      <= '0;
      occ_q       <= '0;
      ver_q       <= '0;
      ovf_q       <= '0;
      dflt_q      <= DefaultLevelRst;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      probes_q    <= '0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      head_q      <= head_d;
      occ_q       <= occ_d;
      ver_q       <= ver_d;
      ovf_q       <= ovf_d;
      dflt_q      <= dflt_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      probes_q    <= probes_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

`ifndef SYNTHESIS
  // The count of occupied slots can never pass the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= FullOcc)
    else $error("occupancy exceeds table depth");

  // A slot may only be replaced at the ring head when every slot is occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE && probe_full && item_q.func == FUNC_UPDATE) |-> occ_q == FullOcc)
    else $error("eviction with free slots left");

  // The slot memory is never written while the block waits for an item or in S_DONE.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q != S_IDLE && state_q != S_DONE))
    else $error("slot write outside a sweep or probe");

  // A result is loaded into the output register only on leaving S_DONE.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result produced without a finished item");
`endif

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the probed hash table with ring eviction. Items are
// driven through the valid/stall input channel, a behavioural copy of the
// table predicts every result at the moment its item is transferred, and each
// result transfer is compared field by field against the oldest prediction.
// Both channels idle and stall at random, and the miss level register is
// rewritten between phases whilst the block is quiet.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import phtre_pkg::*;

  localparam int unsigned Depth = TableDepthDef;
  // Cycles without any transfer before the run is declared hung. The limit lies
  // well above the slowest item (a full probe or a clear) plus the longest gap
  // and stall, and above the reset sweep.
  localparam int unsigned IdleLimit = 2000;
  // Quiet time at the end: a full probe of the table plus pipeline overhead.
  localparam int unsigned SettleCycles = Depth + 16;
  localparam int unsigned MaxPrinted = 50;

  // Outcome of walking the probe chain for one key.
  typedef enum int {
    PROBE_FREE,
    PROBE_HIT,
    PROBE_FULL
  } probe_e;

  // Clock, reset and every input of the block start at a known value.
  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic signed [7:0] cfg_data = '0;

  // Behavioural copy of the table, advanced once per transferred item.
  bit                tab_used  [Depth];
  logic [31:0]       tab_key   [Depth];
  logic signed [7:0] tab_level [Depth];
  logic [15:0]       tab_count [Depth];
  logic [31:0]       tab_stamp [Depth];
  logic [31:0]       version_ctr = '0;
  int unsigned       ring_head   = 0;
  logic [6:0]        fill_count  = '0;
  logic [31:0]       ovf_ctr     = '0;
  logic signed [7:0] miss_level  = DefaultLevelRst;

  // Results still owed by the block, oldest first.
  out_item_t   pending_results [$];
  int unsigned mismatches  = 0;
  int unsigned stall_left  = 0;
  int unsigned idle_cycles = 0;
  // When set, neither side inserts gaps or stalls.
  bit          no_idle     = 1'b0;

  always #2 clk_i = ~clk_i;

  probed_hash_table_with_ring_eviction DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Walks forward from the home slot, wrapping, and stops at the first free
  // slot or at the slot holding the key. Every key value is an ordinary key,
  // the empty marker included, since occupancy is tracked separately.
  function automatic probe_e find_slot(input logic [31:0] key, output int unsigned slot);
    int unsigned idx;
    int unsigned n;
    idx  = key % Depth;
    slot = 0;
    for (n = 0; n < Depth; n++) begin
      if (!tab_used[idx]) begin
        slot = idx;
        return PROBE_FREE;
      end
      if (tab_key[idx] == key) begin
        slot = idx;
        return PROBE_HIT;
      end
      idx = (idx + 1) % Depth;
    end
    return PROBE_FULL;
  endfunction

  // Applies one item to the table copy and returns the result it must cause.
  function automatic out_item_t table_result(input in_item_t it);
    out_item_t   res;
    probe_e      outcome;
    int unsigned slot;
    int unsigned n;
    res = '0;
    case (it.func)
      FUNC_UPDATE: begin
        version_ctr++;
        outcome = find_slot(it.key, slot);
        if (outcome == PROBE_FULL) begin
          // Table full and key absent: the ring head slot is overwritten.
          ovf_ctr++;
          slot        = ring_head;
          ring_head   = (ring_head + 1) % Depth;
          res.evicted = 1'b1;
        end else if (outcome == PROBE_FREE) begin
          fill_count++;
        end
        tab_used[slot]  = 1'b1;
        tab_key[slot]   = it.key;
        tab_level[slot] = it.level_dbm;
        tab_count[slot] = it.hit_count;
        tab_stamp[slot] = it.now_time;
      end
      FUNC_LOOKUP: begin
        outcome = find_slot(it.key, slot);
        if (outcome == PROBE_HIT) begin
          res.found     = 1'b1;
          res.out_level = tab_level[slot];
          res.out_count = tab_count[slot];
          res.out_time  = tab_stamp[slot];
        end else begin
          res.out_level = miss_level;
        end
      end
      FUNC_CLEAR: begin
        // The overflow counter survives a clear.
        for (n = 0; n < Depth; n++) begin
          tab_used[n] = 1'b0;
          tab_key[n]  = EmptyKeyDef;
        end
        ring_head  = 0;
        fill_count = '0;
        version_ctr++;
      end
      FUNC_RST_OVF: begin
        ovf_ctr = '0;
      end
      default: ;
    endcase
    res.version_now  = version_ctr;
    res.used_entries = fill_count;
    res.overflows    = ovf_ctr;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MaxPrinted) begin
      $display("%0t ns: %s got %0h, expected %0h", $time, what, got, want);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing outstanding, version", got.version_now, '0);
      return;
    end
    want = pending_results.pop_front();
    if (got.found !== want.found) begin
      report_mismatch("found", 32'(got.found), 32'(want.found));
    end
    if (got.evicted !== want.evicted) begin
      report_mismatch("evicted", 32'(got.evicted), 32'(want.evicted));
    end
    if (got.out_level !== want.out_level) begin
      report_mismatch("out_level", 32'(got.out_level), 32'(want.out_level));
    end
    if (got.out_count !== want.out_count) begin
      report_mismatch("out_count", 32'(got.out_count), 32'(want.out_count));
    end
    if (got.out_time !== want.out_time) report_mismatch("out_time", got.out_time, want.out_time);
    if (got.version_now !== want.version_now) begin
      report_mismatch("version_now", got.version_now, want.version_now);
    end
    if (got.used_entries !== want.used_entries) begin
      report_mismatch("used_entries", 32'(got.used_entries), 32'(want.used_entries));
    end
    if (got.overflows !== want.overflows) begin
      report_mismatch("overflows", got.overflows, want.overflows);
    end
  endtask

  // Result side. Outputs are sampled at the rising edge, before anything
  // driven at that edge takes effect. After each result transfer a fresh
  // stall length is drawn; it only counts down whilst a result is offered,
  // so every stall really holds a result back.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      check_result(out_data);
      stall_left = no_idle ? 0 : $urandom_range(0, 10);
    end else if (rst_ni && out_valid && stall_left != 0) begin
      stall_left--;
    end
    out_stall <= (stall_left != 0);
  end

  // Watchdog: any transfer on any channel restarts the count.
  initial begin
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  function automatic in_item_t make_item(input func_e f, input logic [31:0] key,
                                         input logic [15:0] cnt,
                                         input logic signed [7:0] lvl,
                                         input logic [31:0] stamp);
    in_item_t it;
    it.func      = f;
    it.key       = key;
    it.hit_count = cnt;
    it.level_dbm = lvl;
    it.now_time  = stamp;
    return it;
  endfunction

  // Same, with random payload fields.
  function automatic in_item_t rand_item(input func_e f, input logic [31:0] key);
    return make_item(f, key, 16'($urandom()), 8'($urandom()), $urandom());
  endfunction

  // Sends one item and predicts its result once it has been transferred.
  // Always entered and left at a rising edge. Valid is only dropped when a
  // gap is drawn, so back-to-back items keep it high throughout.
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    pending_results.push_back(table_result(it));
  endtask

  // Stops sending and waits for every outstanding result. Every item causes
  // exactly one result, so an empty queue means the block is idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Rewrites the level returned on a lookup miss, only once the block is idle.
  task automatic set_miss_level(input logic signed [7:0] lvl);
    wait_idle();
    cfg_data  <= lvl;
    cfg_valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    miss_level = lvl;
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes, the empty marker used as a key, collisions at the home
  // slot, a probe chain that wraps past the last slot, overwrite of an
  // existing key, a miss that walks a chain, overflow reset and clear. Runs
  // with the miss level still at its reset value.
  task automatic test_basic_ops();
    send_item(make_item(FUNC_LOOKUP, EmptyKeyDef, '0, '0, '0));
    send_item(make_item(FUNC_UPDATE, EmptyKeyDef, 16'hFFFF, -8'sd128, 32'hFFFF_FFFF));
    send_item(make_item(FUNC_LOOKUP, EmptyKeyDef, 16'hFFFF, 8'sd127, 32'hFFFF_FFFF));
    // Same home slot as key zero, so it lands one slot further on.
    send_item(make_item(FUNC_UPDATE, 32'd64, 16'h0000, 8'sd127, 32'h0000_0000));
    send_item(make_item(FUNC_UPDATE, 32'hFFFF_FFFF, 16'h1234, -8'sd1, 32'h5A5A_5A5A));
    // Home slot is the last one, which is taken: the walk wraps to the start.
    send_item(make_item(FUNC_UPDATE, 32'hFFFF_FFBF, 16'h8001, 8'sd64, 32'hA5A5_A5A5));
    send_item(make_item(FUNC_LOOKUP, 32'hFFFF_FFBF, '0, '0, '0));
    send_item(make_item(FUNC_LOOKUP, 32'd128, 16'hFFFF, -8'sd128, 32'hFFFF_FFFF));
    send_item(make_item(FUNC_UPDATE, 32'd64, 16'hAAAA, 8'sd1, 32'h0000_0001));
    send_item(make_item(FUNC_LOOKUP, 32'd64, '0, '0, '0));
    send_item(make_item(FUNC_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0));
    send_item(make_item(FUNC_RST_OVF, 32'hFFFF_FFFF, 16'hFFFF, -8'sd1, 32'hFFFF_FFFF));
    send_item(make_item(FUNC_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, -8'sd1, 32'hFFFF_FFFF));
    send_item(make_item(FUNC_LOOKUP, EmptyKeyDef, '0, '0, '0));
    send_item(make_item(FUNC_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0));
    send_item(make_item(FUNC_UPDATE, 32'hFFFF_FFFF, 16'h5555, -8'sd100, 32'h1357_9BDF));
    send_item(make_item(FUNC_RST_OVF, '0, '0, '0, '0));
  endtask

  // Each miss level setting, extremes first, checked with a miss and a hit.
  task automatic test_miss_level();
    logic signed [7:0] levels [4];
    logic [31:0]       key;
    int unsigned       n;
    levels = '{-8'sd128, 8'sd127, 8'sd0, 8'($urandom())};
    for (n = 0; n < 4; n++) begin
      set_miss_level(levels[n]);
      key = $urandom();
      send_item(rand_item(FUNC_LOOKUP, key ^ 32'h8000_0000));
      send_item(rand_item(FUNC_UPDATE, key));
      send_item(rand_item(FUNC_LOOKUP, key));
    end
  endtask

  // Fills every slot, then keeps adding new keys so that the ring head goes
  // all the way round and wraps. Lookups in between hit surviving keys and
  // miss evicted ones; a miss on a full table walks all the slots.
  task automatic test_ring_eviction();
    logic [31:0] ring_keys [$];
    logic [31:0] key;
    int unsigned n;
    send_item(rand_item(FUNC_CLEAR, $urandom()));
    for (n = 0; n < Depth; n++) begin
      key = ($urandom() & 32'hFFFF_FFC0) | n;
      ring_keys.push_back(key);
      send_item(rand_item(FUNC_UPDATE, key));
    end
    for (n = 0; n < Depth + 16; n++) begin
      // Once n reaches half the table depth, the loop runs without gaps or stalls.
      no_idle = (n >= Depth / 2);
      key = $urandom();
      send_item(rand_item(FUNC_UPDATE, key));
      if (n % 4 == 0) begin
        send_item(rand_item(FUNC_LOOKUP, ring_keys[$urandom_range(0, ring_keys.size() - 1)]));
        send_item(rand_item(FUNC_LOOKUP, key));
      end
      ring_keys.push_back(key);
    end
    no_idle = 1'b0;
    send_item(rand_item(FUNC_RST_OVF, $urandom()));
    send_item(rand_item(FUNC_UPDATE, $urandom()));
    send_item(rand_item(FUNC_CLEAR, $urandom()));
  endtask

  // Phases of mostly well-formed traffic over a key set of varying size.
  // Small sets keep the table partly empty, sets beyond the depth force
  // evictions, and crowded sets share a handful of home slots so that probe
  // chains grow long. A little noise with arbitrary keys and operations is
  // mixed in. The miss level is rewritten before every phase.
  task automatic test_random_traffic();
    int unsigned pool_sizes [5];
    logic [31:0] key_set [$];
    logic [31:0] key;
    bit          crowded;
    int unsigned clear_pct;
    int unsigned roll;
    int unsigned ph;
    int unsigned n;
    pool_sizes = '{16, 48, 64, 80, 200};
    for (ph = 0; ph < 7; ph++) begin
      set_miss_level(8'($urandom()));
      crowded   = 1'($urandom_range(0, 1));
      clear_pct = $urandom_range(0, 1) * 2;
      key_set.delete();
      for (n = 0; n < pool_sizes[ph % 5]; n++) begin
        key = $urandom();
        if (crowded) key = (key & 32'hFFFF_FFC0) | $urandom_range(0, 7);
        key_set.push_back(key);
      end
      for (n = 0; n < 160; n++) begin
        if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        key  = key_set[$urandom_range(0, key_set.size() - 1)];
        roll = $urandom_range(0, 99);
        if (roll < clear_pct) begin
          send_item(rand_item(FUNC_CLEAR, $urandom()));
        end else if (roll < 4) begin
          send_item(rand_item(FUNC_RST_OVF, $urandom()));
        end else if (roll < 8) begin
          send_item(rand_item(func_e'($urandom_range(0, 3)), $urandom()));
        end else if (roll < 58) begin
          send_item(rand_item(FUNC_UPDATE, key));
        end else begin
          send_item(rand_item(FUNC_LOOKUP, key));
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_basic_ops();
    test_miss_level();
    test_ring_eviction();
    test_random_traffic();
    wait_idle();
    // Anything arriving now has no prediction and is flagged by the checker.
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
